/* src/aiffcw_pkg.sv */
// Shared types, tags and status codes for the AIFF chunk walker.
`default_nettype none
package aiffcw_pkg;

    typedef enum logic [2:0] {
        PH_FORM,
        PH_FSIZE,
        PH_TYPE,
        PH_CKID,
        PH_CKSIZE,
        PH_BODY,
        PH_DONE,
        PH_DRAIN
    } phase_t;

    typedef enum logic [1:0] {
        CK_OTHER,
        CK_COMM,
        CK_SSND
    } chunk_kind_t;

    typedef enum logic [2:0] {
        OP_NONE,
        OP_WORD,
        OP_SIZE,
        OP_COMM,
        OP_SSND
    } dp_op_t;

    localparam logic [31:0] TAG_FORM = 32'h464F524D;
    localparam logic [31:0] TAG_AIFF = 32'h41494646;
    localparam logic [31:0] TAG_COMM = 32'h434F4D4D;
    localparam logic [31:0] TAG_SSND = 32'h53534E44;

    localparam logic [31:0] COMM_MIN_SIZE = 32'd18;
    localparam logic [31:0] SSND_MIN_SIZE = 32'd8;
    localparam logic [31:0] SSND_HDR_LAST = 32'd7;
    localparam logic [31:0] WORD_LAST     = 32'd3;
    localparam logic [7:0]  RATE_BIAS     = 8'd30;

    localparam logic [3:0] ST_OK        = 4'd0;
    localparam logic [3:0] ST_NO_FORM   = 4'd1;
    localparam logic [3:0] ST_NO_AIFF   = 4'd2;
    localparam logic [3:0] ST_DUP_COMM  = 4'd3;
    localparam logic [3:0] ST_DUP_SSND  = 4'd4;
    localparam logic [3:0] ST_MISSING   = 4'd5;
    localparam logic [3:0] ST_SIZE      = 4'd6;
    localparam logic [3:0] ST_TRUNCATED = 4'd8;
    localparam logic [3:0] ST_MALFORMED = 4'd9;
    localparam logic [3:0] ST_ORDER     = 4'd10;

    typedef struct packed {
        dp_op_t      op;
        logic [31:0] index;
        logic        clear;
    } dp_cmd_t;

    typedef struct packed {
        logic [31:0] word;
        logic        chunk_last;
        logic        depth_bad;
        logic        ssnd_overflow;
        logic        sample_fire;
        logic        size_mismatch;
    } dp_stat_t;

    typedef struct packed {
        logic       sample_fire;
        logic       status_fire;
        logic [3:0] status;
    } emit_t;

endpackage
`default_nettype wire

/* src/aiffcw_ctrl.sv */
// Chunk walk controller: phase, byte counts, chunk order and error tracking.
`default_nettype none
module aiffcw_ctrl (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                take,
    input  wire logic                end_of_file,
    input  wire aiffcw_pkg::dp_stat_t stat,
    output aiffcw_pkg::dp_cmd_t      cmd,
    output aiffcw_pkg::emit_t        emit
);

    aiffcw_pkg::phase_t      phase_reg, phase_next;
    aiffcw_pkg::chunk_kind_t kind_reg, kind_next;
    logic [31:0] cnt_reg, cnt_next;
    logic [31:0] form_rem_reg, form_rem_next;
    logic        comm_seen_reg, comm_seen_next;
    logic        ssnd_seen_reg, ssnd_seen_next;
    logic [3:0]  err_reg, err_next;
    logic [3:0]  final_status;

    always_comb
    begin
        logic [3:0] code;
        logic       fail;
        logic       end_chunk;
        phase_next     = phase_reg;
        kind_next      = kind_reg;
        cnt_next       = cnt_reg;
        form_rem_next  = form_rem_reg;
        comm_seen_next = comm_seen_reg;
        ssnd_seen_next = ssnd_seen_reg;
        err_next       = err_reg;
        code           = aiffcw_pkg::ST_OK;
        fail           = 1'b0;
        end_chunk      = 1'b0;
        final_status   = aiffcw_pkg::ST_OK;
        if (take)
        begin
            if ((phase_reg == aiffcw_pkg::PH_TYPE || phase_reg == aiffcw_pkg::PH_CKID ||
                 phase_reg == aiffcw_pkg::PH_CKSIZE || phase_reg == aiffcw_pkg::PH_BODY) &&
                form_rem_reg != 32'd0)
            begin
                form_rem_next = form_rem_reg - 32'd1;
            end
            case (phase_reg)
                aiffcw_pkg::PH_FORM, aiffcw_pkg::PH_FSIZE, aiffcw_pkg::PH_TYPE,
                aiffcw_pkg::PH_CKID, aiffcw_pkg::PH_CKSIZE:
                begin
                    if (cnt_reg != aiffcw_pkg::WORD_LAST)
                    begin
                        cnt_next = cnt_reg + 32'd1;
                    end
                    else
                    begin
                        cnt_next = 32'd0;
                        case (phase_reg)
                            aiffcw_pkg::PH_FORM:
                            begin
                                if (stat.word == aiffcw_pkg::TAG_FORM)
                                    phase_next = aiffcw_pkg::PH_FSIZE;
                                else
                                begin
                                    fail = 1'b1;
                                    code = aiffcw_pkg::ST_NO_FORM;
                                end
                            end
                            aiffcw_pkg::PH_FSIZE:
                            begin
                                form_rem_next = stat.word;
                                phase_next    = aiffcw_pkg::PH_TYPE;
                            end
                            aiffcw_pkg::PH_TYPE:
                            begin
                                if (stat.word == aiffcw_pkg::TAG_AIFF)
                                    phase_next = aiffcw_pkg::PH_CKID;
                                else
                                begin
                                    fail = 1'b1;
                                    code = aiffcw_pkg::ST_NO_AIFF;
                                end
                            end
                            aiffcw_pkg::PH_CKID:
                            begin
                                phase_next = aiffcw_pkg::PH_CKSIZE;
                                if (stat.word == aiffcw_pkg::TAG_COMM)
                                begin
                                    if (comm_seen_reg)
                                    begin
                                        fail = 1'b1;
                                        code = aiffcw_pkg::ST_DUP_COMM;
                                    end
                                    else
                                    begin
                                        comm_seen_next = 1'b1;
                                        kind_next      = aiffcw_pkg::CK_COMM;
                                    end
                                end
                                else if (stat.word == aiffcw_pkg::TAG_SSND)
                                begin
                                    if (ssnd_seen_reg)
                                    begin
                                        fail = 1'b1;
                                        code = aiffcw_pkg::ST_DUP_SSND;
                                    end
                                    else if (!comm_seen_reg)
                                    begin
                                        fail = 1'b1;
                                        code = aiffcw_pkg::ST_ORDER;
                                    end
                                    else
                                    begin
                                        ssnd_seen_next = 1'b1;
                                        kind_next      = aiffcw_pkg::CK_SSND;
                                    end
                                end
                                else
                                begin
                                    kind_next = aiffcw_pkg::CK_OTHER;
                                end
                            end
                            default:
                            begin
                                if ((kind_reg == aiffcw_pkg::CK_COMM &&
                                     stat.word < aiffcw_pkg::COMM_MIN_SIZE) ||
                                    (kind_reg == aiffcw_pkg::CK_SSND &&
                                     stat.word < aiffcw_pkg::SSND_MIN_SIZE))
                                begin
                                    fail = 1'b1;
                                    code = aiffcw_pkg::ST_MALFORMED;
                                end
                                else if (stat.word == 32'd0)
                                    end_chunk = 1'b1;
                                else
                                    phase_next = aiffcw_pkg::PH_BODY;
                            end
                        endcase
                    end
                end
                aiffcw_pkg::PH_BODY:
                begin
                    if (cnt_reg == aiffcw_pkg::SSND_HDR_LAST &&
                        ((kind_reg == aiffcw_pkg::CK_COMM && stat.depth_bad) ||
                         (kind_reg == aiffcw_pkg::CK_SSND && stat.ssnd_overflow)))
                    begin
                        fail = 1'b1;
                        code = aiffcw_pkg::ST_MALFORMED;
                    end
                    else if (stat.chunk_last)
                        end_chunk = 1'b1;
                    else
                        cnt_next = cnt_reg + 32'd1;
                end
                default:
                begin
                end
            endcase
            if (end_chunk)
            begin
                phase_next = (form_rem_next == 32'd0) ? aiffcw_pkg::PH_DONE
                                                      : aiffcw_pkg::PH_CKID;
                cnt_next   = 32'd0;
            end
            if (fail)
            begin
                if (err_reg == aiffcw_pkg::ST_OK)
                    err_next = code;
                phase_next = aiffcw_pkg::PH_DRAIN;
            end
            if (err_next != aiffcw_pkg::ST_OK)
                final_status = err_next;
            else if (phase_next != aiffcw_pkg::PH_DONE)
                final_status = aiffcw_pkg::ST_TRUNCATED;
            else if (!comm_seen_next || !ssnd_seen_next)
                final_status = aiffcw_pkg::ST_MISSING;
            else if (stat.size_mismatch)
                final_status = aiffcw_pkg::ST_SIZE;
            if (end_of_file)
            begin
                phase_next     = aiffcw_pkg::PH_FORM;
                kind_next      = aiffcw_pkg::CK_OTHER;
                cnt_next       = 32'd0;
                form_rem_next  = 32'd0;
                comm_seen_next = 1'b0;
                ssnd_seen_next = 1'b0;
                err_next       = aiffcw_pkg::ST_OK;
            end
        end
    end

    always_comb
    begin
        cmd.op    = aiffcw_pkg::OP_NONE;
        cmd.index = cnt_reg;
        cmd.clear = take & end_of_file;
        if (take)
        begin
            case (phase_reg)
                aiffcw_pkg::PH_FORM, aiffcw_pkg::PH_FSIZE, aiffcw_pkg::PH_TYPE,
                aiffcw_pkg::PH_CKID:
                    cmd.op = aiffcw_pkg::OP_WORD;
                aiffcw_pkg::PH_CKSIZE:
                    cmd.op = (cnt_reg == aiffcw_pkg::WORD_LAST) ? aiffcw_pkg::OP_SIZE
                                                                : aiffcw_pkg::OP_WORD;
                aiffcw_pkg::PH_BODY:
                begin
                    case (kind_reg)
                        aiffcw_pkg::CK_COMM: cmd.op = aiffcw_pkg::OP_COMM;
                        aiffcw_pkg::CK_SSND: cmd.op = aiffcw_pkg::OP_SSND;
                        default:             cmd.op = aiffcw_pkg::OP_NONE;
                    endcase
                end
                default:
                    cmd.op = aiffcw_pkg::OP_NONE;
            endcase
        end
        emit.sample_fire = take & stat.sample_fire;
        emit.status_fire = take & end_of_file;
        emit.status      = final_status;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= aiffcw_pkg::PH_FORM;
            kind_reg      <= aiffcw_pkg::CK_OTHER;
            cnt_reg       <= 32'd0;
            form_rem_reg  <= 32'd0;
            comm_seen_reg <= 1'b0;
            ssnd_seen_reg <= 1'b0;
            err_reg       <= aiffcw_pkg::ST_OK;
        end
        else
        begin
            phase_reg     <= phase_next;
            kind_reg      <= kind_next;
            cnt_reg       <= cnt_next;
            form_rem_reg  <= form_rem_next;
            comm_seen_reg <= comm_seen_next;
            ssnd_seen_reg <= ssnd_seen_next;
            err_reg       <= err_next;
        end
    end

endmodule
`default_nettype wire

/* src/aiffcw_dp.sv */
// Datapath: tag word, chunk fields, COMM values, SSND window, samples and rate.
`default_nettype none
module aiffcw_dp (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic [7:0]          data_byte,
    input  wire aiffcw_pkg::dp_cmd_t cmd,
    output aiffcw_pkg::dp_stat_t     stat,
    output logic signed [31:0]       sample_next,
    output logic [15:0]              channels_view,
    output logic [31:0]              frames_view,
    output logic [15:0]              depth_view,
    output logic [31:0]              rate_view
);

    logic [31:0] word_reg, word_next;
    logic [31:0] size_reg, size_next;
    logic [15:0] chan_reg, chan_next;
    logic [31:0] frames_reg, frames_next;
    logic [15:0] depth_reg, depth_next;
    logic [7:0]  exp_reg, exp_next;
    logic [31:0] mant_reg, mant_next;
    logic [31:0] off_reg, off_next;
    logic [31:0] block_reg, block_next;
    logic [31:0] sound_reg, sound_next;
    logic [31:0] asm_reg, asm_next;
    logic [2:0]  fs_reg, fs_next;
    logic [47:0] p1_reg;
    logic [50:0] p2_reg;

    logic [32:0] padded;
    logic [33:0] used;
    logic [31:0] rel;
    logic [31:0] asm_new;
    logic [2:0]  nbytes;
    logic [2:0]  fs_inc;
    logic        in_window;
    logic [7:0]  shift_n;
    logic [31:0] rate_shifted;
    logic        rate_round;
    logic [15:0] depth_new;

    assign nbytes    = depth_reg[5:3];
    assign depth_new = {depth_reg[7:0], data_byte};
    assign padded    = {1'b0, size_reg} + {32'd0, size_reg[0]};
    assign used      = {2'b00, off_reg} + {2'b00, block_reg[23:0], data_byte} + 34'd8;
    assign rel       = cmd.index - 32'd8;
    assign in_window = (cmd.index >= 32'd8) && (rel >= off_reg) &&
                       ((rel - off_reg) < sound_reg);
    assign asm_new   = {asm_reg[23:0], data_byte};
    assign fs_inc    = fs_reg + 3'd1;

    always_comb
    begin
        case (nbytes)
            3'd1:    sample_next = {{24{asm_new[7]}}, asm_new[7:0]};
            3'd2:    sample_next = {{16{asm_new[15]}}, asm_new[15:0]};
            3'd3:    sample_next = {{8{asm_new[23]}}, asm_new[23:0]};
            default: sample_next = asm_new;
        endcase
    end

    always_comb
    begin
        stat.word          = {word_reg[23:0], data_byte};
        stat.chunk_last    = ({1'b0, cmd.index} + 33'd1) == padded;
        stat.depth_bad     = (depth_new[15:3] == 13'd0) || (depth_new[15:3] > 13'd4);
        stat.ssnd_overflow = used > {2'b00, size_reg};
        stat.sample_fire   = (cmd.op == aiffcw_pkg::OP_SSND) && in_window &&
                             (fs_inc >= nbytes);
        stat.size_mismatch = p2_reg != {19'd0, sound_reg};
    end

    always_comb
    begin
        word_next   = word_reg;
        size_next   = size_reg;
        chan_next   = chan_reg;
        frames_next = frames_reg;
        depth_next  = depth_reg;
        exp_next    = exp_reg;
        mant_next   = mant_reg;
        off_next    = off_reg;
        block_next  = block_reg;
        sound_next  = sound_reg;
        asm_next    = asm_reg;
        fs_next     = fs_reg;
        case (cmd.op)
            aiffcw_pkg::OP_WORD:
                word_next = stat.word;
            aiffcw_pkg::OP_SIZE:
            begin
                word_next = stat.word;
                size_next = stat.word;
            end
            aiffcw_pkg::OP_COMM:
            begin
                if (cmd.index < 32'd2)
                    chan_next = {chan_reg[7:0], data_byte};
                else if (cmd.index < 32'd6)
                    frames_next = {frames_reg[23:0], data_byte};
                else if (cmd.index < 32'd8)
                    depth_next = depth_new;
                else if (cmd.index == 32'd9)
                    exp_next = data_byte;
                else if (cmd.index >= 32'd10 && cmd.index < 32'd14)
                    mant_next = {mant_reg[23:0], data_byte};
            end
            aiffcw_pkg::OP_SSND:
            begin
                if (cmd.index < 32'd4)
                    off_next = {off_reg[23:0], data_byte};
                else if (cmd.index < 32'd8)
                begin
                    block_next = {block_reg[23:0], data_byte};
                    if (cmd.index == aiffcw_pkg::SSND_HDR_LAST)
                        sound_next = size_reg - used[31:0];
                end
                else if (in_window)
                begin
                    asm_next = asm_new;
                    fs_next  = (fs_inc >= nbytes) ? 3'd0 : fs_inc;
                end
            end
            default:
            begin
            end
        endcase
    end

    always_comb
    begin
        shift_n      = aiffcw_pkg::RATE_BIAS - exp_next;
        rate_shifted = mant_next >> shift_n;
        rate_round   = 1'b0;
        if (shift_n != 8'd0)
            rate_round = ((mant_next >> (shift_n - 8'd1)) & 32'd1) != 32'd0;
        rate_view     = rate_shifted + {31'd0, rate_round};
        channels_view = chan_next;
        frames_view   = frames_next;
        depth_view    = depth_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            word_reg   <= 32'd0;
            size_reg   <= 32'd0;
            chan_reg   <= 16'd0;
            frames_reg <= 32'd0;
            depth_reg  <= 16'd0;
            exp_reg    <= 8'd0;
            mant_reg   <= 32'd0;
            off_reg    <= 32'd0;
            block_reg  <= 32'd0;
            sound_reg  <= 32'd0;
            asm_reg    <= 32'd0;
            fs_reg     <= 3'd0;
            p1_reg     <= 48'd0;
            p2_reg     <= 51'd0;
        end
        else
        begin
            p1_reg <= frames_reg * chan_reg;
            p2_reg <= ({51{nbytes[0]}} & {3'd0, p1_reg}) +
                      ({51{nbytes[1]}} & {2'd0, p1_reg, 1'b0}) +
                      ({51{nbytes[2]}} & {1'b0, p1_reg, 2'b00});
            if (cmd.clear)
            begin
                word_reg   <= 32'd0;
                size_reg   <= 32'd0;
                chan_reg   <= 16'd0;
                frames_reg <= 32'd0;
                depth_reg  <= 16'd0;
                exp_reg    <= 8'd0;
                mant_reg   <= 32'd0;
                off_reg    <= 32'd0;
                block_reg  <= 32'd0;
                sound_reg  <= 32'd0;
                asm_reg    <= 32'd0;
                fs_reg     <= 3'd0;
            end
            else
            begin
                word_reg   <= word_next;
                size_reg   <= size_next;
                chan_reg   <= chan_next;
                frames_reg <= frames_next;
                depth_reg  <= depth_next;
                exp_reg    <= exp_next;
                mant_reg   <= mant_next;
                off_reg    <= off_next;
                block_reg  <= block_next;
                sound_reg  <= sound_next;
                asm_reg    <= asm_next;
                fs_reg     <= fs_next;
            end
        end
    end

endmodule
`default_nettype wire

/* src/aiff_chunk_walker.sv */
// Top level: AIFF chunk walker with controller, datapath and result register.
`default_nettype none
// Takes an AIFF file one byte per item and returns decoded samples, then one
// final status item flagged last on the byte marked end_of_file; the block
// then rearms for the next file. A byte that yields no result is taken every
// cycle while no result waits in the output register. A byte that yields
// results is followed by data_stall until they are delivered: one result
// frees the input in the cycle after it is taken; for a sample plus status
// on the same byte the output register holds the status pending behind it.
module aiff_chunk_walker (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               data_valid,
    output logic                    data_stall,
    input  wire logic [7:0]         data_byte,
    input  wire logic               end_of_file,
    output logic                    result_valid,
    input  wire logic               result_stall,
    output logic                    kind,
    output logic signed [31:0]      sample_value,
    output logic [3:0]              status,
    output logic [15:0]             channel_count,
    output logic [31:0]             frame_count,
    output logic [15:0]             bit_depth,
    output logic [31:0]             sample_rate,
    output logic                    last
);

    aiffcw_pkg::dp_cmd_t  cmd;
    aiffcw_pkg::dp_stat_t stat;
    aiffcw_pkg::emit_t    emit;
    logic               take;
    logic signed [31:0] sample_next;
    logic [15:0]        channels_view;
    logic [31:0]        frames_view;
    logic [15:0]        depth_view;
    logic [31:0]        rate_view;

    logic               valid_reg, valid_next;
    logic               pend_reg, pend_next;
    logic [3:0]         pend_status_reg, pend_status_next;
    logic               kind_reg, kind_next;
    logic signed [31:0] value_reg, value_next;
    logic [3:0]         status_reg, status_next;
    logic               last_reg, last_next;
    logic [15:0]        chan_reg, chan_next;
    logic [31:0]        frames_reg, frames_next;
    logic [15:0]        depth_reg, depth_next;
    logic [31:0]        rate_reg, rate_next;

    assign data_stall = valid_reg | pend_reg;
    assign take       = data_valid & ~data_stall;

    aiffcw_ctrl u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .take        (take),
        .end_of_file (end_of_file),
        .stat        (stat),
        .cmd         (cmd),
        .emit        (emit)
    );

    aiffcw_dp u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .data_byte     (data_byte),
        .cmd           (cmd),
        .stat          (stat),
        .sample_next   (sample_next),
        .channels_view (channels_view),
        .frames_view   (frames_view),
        .depth_view    (depth_view),
        .rate_view     (rate_view)
    );

    always_comb
    begin
        valid_next       = valid_reg;
        pend_next        = pend_reg;
        pend_status_next = pend_status_reg;
        kind_next        = kind_reg;
        value_next       = value_reg;
        status_next      = status_reg;
        last_next        = last_reg;
        chan_next        = chan_reg;
        frames_next      = frames_reg;
        depth_next       = depth_reg;
        rate_next        = rate_reg;
        if (valid_reg && !result_stall)
        begin
            valid_next = pend_reg;
            if (pend_reg)
            begin
                pend_next   = 1'b0;
                kind_next   = 1'b1;
                value_next  = 32'sd0;
                status_next = pend_status_reg;
                last_next   = 1'b1;
            end
        end
        if (emit.sample_fire || emit.status_fire)
        begin
            valid_next  = 1'b1;
            chan_next   = channels_view;
            frames_next = frames_view;
            depth_next  = depth_view;
            rate_next   = rate_view;
            if (emit.sample_fire)
            begin
                kind_next        = 1'b0;
                value_next       = sample_next;
                status_next      = aiffcw_pkg::ST_OK;
                last_next        = 1'b0;
                pend_next        = emit.status_fire;
                pend_status_next = emit.status;
            end
            else
            begin
                kind_next   = 1'b1;
                value_next  = 32'sd0;
                status_next = emit.status;
                last_next   = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            pend_reg  <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
            pend_reg  <= pend_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pend_status_reg <= pend_status_next;
        kind_reg        <= kind_next;
        value_reg       <= value_next;
        status_reg      <= status_next;
        last_reg        <= last_next;
        chan_reg        <= chan_next;
        frames_reg      <= frames_next;
        depth_reg       <= depth_next;
        rate_reg        <= rate_next;
    end

    assign result_valid  = valid_reg;
    assign kind          = kind_reg;
    assign sample_value  = value_reg;
    assign status        = status_reg;
    assign channel_count = chan_reg;
    assign frame_count   = frames_reg;
    assign bit_depth     = depth_reg;
    assign sample_rate   = rate_reg;
    assign last          = last_reg;

endmodule
`default_nettype wire

/* dv/aiff_chunk_walker_checker.sv */
// Checker for the AIFF chunk walker: file walk prediction and result comparison.
module aiff_chunk_walker_checker (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               data_valid,
    input  wire logic               data_stall,
    input  wire logic [7:0]         data_byte,
    input  wire logic               end_of_file,
    input  wire logic               result_valid,
    input  wire logic               result_stall,
    input  wire logic               kind,
    input  wire logic signed [31:0] sample_value,
    input  wire logic [3:0]         status,
    input  wire logic [15:0]        channel_count,
    input  wire logic [31:0]        frame_count,
    input  wire logic [15:0]        bit_depth,
    input  wire logic [31:0]        sample_rate,
    input  wire logic               last,
    output int                      failures,
    output int                      pending,
    output int                      samples_seen,
    output int                      files_seen
);

    localparam logic [3:0] ST_RANGE = 4'd7;

    typedef struct packed {
        logic        kind;
        logic [31:0] value;
        logic [3:0]  status;
        logic [15:0] channels;
        logic [31:0] frames;
        logic [15:0] depth;
        logic [31:0] rate;
        logic        last;
    } walk_result_t;

    walk_result_t expected_results[$];

    aiffcw_pkg::phase_t      ph;
    aiffcw_pkg::chunk_kind_t ck;
    logic [32:0] form_left;
    logic [31:0] cnt, shift_n, ck_size, word;
    logic        have_comm, have_ssnd;
    logic [3:0]  err;
    logic [15:0] chans, depth;
    logic [31:0] frames;
    logic [7:0]  exp_lo;
    logic [31:0] mant, offs, blk, snd_len, asm_word;

    task automatic rearm();
        ph = aiffcw_pkg::PH_FORM; ck = aiffcw_pkg::CK_OTHER; form_left = '0; cnt = '0;
        shift_n = '0; ck_size = '0; word = '0; have_comm = 0; have_ssnd = 0;
        err = aiffcw_pkg::ST_OK;
        chans = '0; depth = '0; frames = '0; exp_lo = '0; mant = '0; offs = '0;
        blk = '0; snd_len = '0; asm_word = '0;
    endtask

    function automatic logic [31:0] rate_now();
        logic [7:0]  n;
        logic [31:0] r;
        logic        lb;
        n = aiffcw_pkg::RATE_BIAS - exp_lo;
        if (n == 0)
            return mant;
        lb = (n - 1 < 32) ? mant[n - 1] : 1'b0;
        r = (n < 32) ? (mant >> n) : 32'd0;
        return r + lb;
    endfunction

    task automatic push_result(logic k, logic [31:0] v, logic [3:0] st, logic l);
        walk_result_t e;
        e = '{k, v, st, chans, frames, depth, rate_now(), l};
        expected_results.push_back(e);
    endtask

    task automatic abort_walk(logic [3:0] code);
        if (err == aiffcw_pkg::ST_OK)
            err = code;
        ph = aiffcw_pkg::PH_DRAIN;
    endtask

    task automatic close_chunk();
        ph = (form_left == 0) ? aiffcw_pkg::PH_DONE : aiffcw_pkg::PH_CKID;
        cnt = 0;
    endtask

    task automatic sound_byte(logic [7:0] b);
        logic [31:0] nb;
        logic [63:0] v, half;
        nb = depth >> 3;
        asm_word = {asm_word[23:0], b};
        shift_n++;
        if (shift_n < nb)
            return;
        shift_n = 0;
        v = 64'(asm_word) & ((64'd1 << (nb * 8)) - 1);
        if (v[nb * 8 - 1])
            v = v - (64'd1 << (nb * 8));
        half = 64'd1 << (depth - 1);
        if ($signed(v) < -$signed(half) || $signed(v) > $signed(half) - 1) begin
            abort_walk(ST_RANGE);
            return;
        end
        push_result(1'b0, v[31:0], aiffcw_pkg::ST_OK, 1'b0);
    endtask

    task automatic body_byte(logic [7:0] b);
        logic [32:0] padded;
        logic [33:0] used;
        logic [32:0] rel;
        padded = 33'(ck_size) + ck_size[0];
        if (ck == aiffcw_pkg::CK_COMM) begin
            if (cnt < 2) chans = {chans[7:0], b};
            else if (cnt < 6) frames = {frames[23:0], b};
            else if (cnt < 8) begin
                depth = {depth[7:0], b};
                if (cnt == 7 && ((depth >> 3) == 0 || (depth >> 3) > 4)) begin
                    abort_walk(aiffcw_pkg::ST_MALFORMED);
                    return;
                end
            end
            else if (cnt == 9) exp_lo = b;
            else if (cnt >= 10 && cnt < 14) mant = {mant[23:0], b};
        end else if (ck == aiffcw_pkg::CK_SSND) begin
            if (cnt < 4) offs = {offs[23:0], b};
            else if (cnt < 8) begin
                blk = {blk[23:0], b};
                if (cnt == 7) begin
                    used = 34'(offs) + 34'(blk) + 34'd8;
                    if (used > 34'(ck_size)) begin
                        abort_walk(aiffcw_pkg::ST_MALFORMED);
                        return;
                    end
                    snd_len = ck_size - used[31:0];
                end
            end else begin
                rel = 33'(cnt) - 33'd8;
                if (rel >= 33'(offs) && rel - 33'(offs) < 33'(snd_len)) begin
                    sound_byte(b);
                    if (ph == aiffcw_pkg::PH_DRAIN)
                        return;
                end
            end
        end
        if (33'(cnt) + 1 == padded)
            close_chunk();
        else
            cnt = cnt + 1;
    endtask

    task automatic take_byte(logic [7:0] b);
        if (ph >= aiffcw_pkg::PH_TYPE && ph <= aiffcw_pkg::PH_BODY && form_left != 0)
            form_left--;
        if (ph == aiffcw_pkg::PH_BODY) begin
            body_byte(b);
            return;
        end
        if (ph == aiffcw_pkg::PH_DONE || ph == aiffcw_pkg::PH_DRAIN)
            return;
        word = {word[23:0], b};
        cnt++;
        if (cnt < 4)
            return;
        cnt = 0;
        case (ph)
            aiffcw_pkg::PH_FORM:
                if (word != aiffcw_pkg::TAG_FORM) abort_walk(aiffcw_pkg::ST_NO_FORM);
                else ph = aiffcw_pkg::PH_FSIZE;
            aiffcw_pkg::PH_FSIZE:
            begin
                form_left = 33'(word);
                ph = aiffcw_pkg::PH_TYPE;
            end
            aiffcw_pkg::PH_TYPE:
                if (word != aiffcw_pkg::TAG_AIFF) abort_walk(aiffcw_pkg::ST_NO_AIFF);
                else ph = aiffcw_pkg::PH_CKID;
            aiffcw_pkg::PH_CKID:
            begin
                if (word == aiffcw_pkg::TAG_COMM) begin
                    if (have_comm) begin
                        abort_walk(aiffcw_pkg::ST_DUP_COMM);
                        return;
                    end
                    have_comm = 1;
                    ck = aiffcw_pkg::CK_COMM;
                end else if (word == aiffcw_pkg::TAG_SSND) begin
                    if (have_ssnd) begin
                        abort_walk(aiffcw_pkg::ST_DUP_SSND);
                        return;
                    end
                    if (!have_comm) begin
                        abort_walk(aiffcw_pkg::ST_ORDER);
                        return;
                    end
                    have_ssnd = 1;
                    ck = aiffcw_pkg::CK_SSND;
                end else
                    ck = aiffcw_pkg::CK_OTHER;
                ph = aiffcw_pkg::PH_CKSIZE;
            end
            default:
            begin
                ck_size = word;
                if ((ck == aiffcw_pkg::CK_COMM && ck_size < aiffcw_pkg::COMM_MIN_SIZE) ||
                    (ck == aiffcw_pkg::CK_SSND && ck_size < aiffcw_pkg::SSND_MIN_SIZE)) begin
                    abort_walk(aiffcw_pkg::ST_MALFORMED);
                    return;
                end
                if (ck_size == 0)
                    close_chunk();
                else
                    ph = aiffcw_pkg::PH_BODY;
            end
        endcase
    endtask

    task automatic accept_byte(logic [7:0] b, logic eof);
        logic [3:0]  st;
        logic [63:0] need;
        take_byte(b);
        if (eof) begin
            st = err;
            if (st == aiffcw_pkg::ST_OK) begin
                need = 64'(depth >> 3) * 64'(frames) * 64'(chans);
                if (ph != aiffcw_pkg::PH_DONE) st = aiffcw_pkg::ST_TRUNCATED;
                else if (!have_comm || !have_ssnd) st = aiffcw_pkg::ST_MISSING;
                else if (need != 64'(snd_len)) st = aiffcw_pkg::ST_SIZE;
            end
            push_result(1'b1, 32'd0, st, 1'b1);
            rearm();
        end
    endtask

    task automatic compare_result();
        walk_result_t got, want;
        got = '{kind, sample_value, status, channel_count, frame_count, bit_depth,
                sample_rate, last};
        if (expected_results.size() == 0) begin
            failures++;
            $display("%0t: unexpected result %h", $realtime, got);
            return;
        end
        want = expected_results.pop_front();
        if (got.kind) files_seen++;
        else samples_seen++;
        if (got !== want) begin
            failures++;
            $display("%0t: mismatch expected kind=%0d val=%h st=%0d ch=%0d fr=%0d",
                     $realtime, want.kind, want.value, want.status, want.channels,
                     want.frames);
            $display("%0t:          expected bd=%0d rate=%0d last=%0d",
                     $realtime, want.depth, want.rate, want.last);
            $display("%0t:          actual   kind=%0d val=%h st=%0d ch=%0d fr=%0d",
                     $realtime, got.kind, got.value, got.status, got.channels,
                     got.frames);
            $display("%0t:          actual   bd=%0d rate=%0d last=%0d",
                     $realtime, got.depth, got.rate, got.last);
        end
    endtask

    initial
    begin
        failures = 0;
        pending = 0;
        samples_seen = 0;
        files_seen = 0;
        rearm();
    end

    always @(posedge clk)
    begin
        if (rst_n) begin
            if (result_valid && !result_stall)
                compare_result();
            if (data_valid && !data_stall)
                accept_byte(data_byte, end_of_file);
            pending = expected_results.size();
        end
    end

endmodule

/* dv/aiff_chunk_walker_test.sv */
// Testbench top for the AIFF chunk walker: file stimulus, idling phases and verdict.
module aiff_chunk_walker_test;

    localparam int IDLE_LIMIT = 2000;

    logic               clk = 0;
    logic               rst_n = 0;
    logic               data_valid = 0;
    logic               data_stall;
    logic [7:0]         data_byte = 0;
    logic               end_of_file = 0;
    logic               result_valid;
    logic               result_stall = 0;
    logic               kind;
    logic signed [31:0] sample_value;
    logic [3:0]         status;
    logic [15:0]        channel_count;
    logic [31:0]        frame_count;
    logic [15:0]        bit_depth;
    logic [31:0]        sample_rate;
    logic               last;
    int                 failures, pending, samples_seen, files_seen;
    int                 send_idle_pct = 0, stall_pct = 0, bytes_sent = 0, quiet_cycles = 0;
    logic [7:0]         file_bytes[$];

    always #5 clk = ~clk;

    aiff_chunk_walker DUT (.*);

    aiff_chunk_walker_checker checker_i (.*);

    always @(negedge clk)
        result_stall <= ($urandom_range(99) < stall_pct);

    always @(posedge clk)
    begin
        if ((data_valid && !data_stall) || (result_valid && !result_stall))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles > IDLE_LIMIT) begin
            $display("watchdog: no progress, %0d results pending", pending);
            $display("aiff_chunk_walker_test: FAIL");
            $finish;
        end
    end

    task automatic put32(logic [31:0] w);
        for (int i = 3; i >= 0; i--)
            file_bytes.push_back(w[i * 8 +: 8]);
    endtask

    task automatic put16(logic [15:0] w);
        file_bytes.push_back(w[15:8]);
        file_bytes.push_back(w[7:0]);
    endtask

    // Stream the queued file, marking the final byte.
    task automatic send_file();
        int n;
        n = file_bytes.size();
        for (int i = 0; i < n; i++) begin
            while ($urandom_range(99) < send_idle_pct) begin
                data_valid <= 0;
                @(negedge clk);
            end
            data_valid <= 1;
            data_byte <= file_bytes[i];
            end_of_file <= (i == n - 1);
            @(posedge clk);
            while (data_stall)
                @(posedge clk);
            @(negedge clk);
            bytes_sent++;
        end
        data_valid <= 0;
        end_of_file <= 0;
        file_bytes.delete();
    endtask

    // Build a file; mode picks a defect, 0 is a clean file.
    task automatic build_file(int mode, int chans, int frames, int depth);
        int          nb, snd, offs, blk, ssnd_size, junk;
        logic [31:0] form_size;
        nb = depth / 8;
        if (nb < 1) nb = 1;
        snd = (depth >= 8 && depth <= 32) ? nb * chans * frames : 3;
        if (mode == 6) snd = snd + $urandom_range(1, 3);
        offs = $urandom_range(0, 2);
        blk = $urandom_range(0, 2);
        ssnd_size = 8 + offs + blk + snd;
        junk = $urandom_range(0, 3);
        form_size = 4 + 26 + (8 + ssnd_size + ssnd_size % 2) + (junk ? 8 + junk + junk % 2 : 0);
        if (mode == 11) form_size = 4;
        if (mode == 12) form_size = form_size + 20;
        put32(mode == 1 ? {$urandom} : aiffcw_pkg::TAG_FORM);
        put32(form_size);
        put32(mode == 2 ? aiffcw_pkg::TAG_FORM : aiffcw_pkg::TAG_AIFF);
        if (mode == 10) begin
            put32(aiffcw_pkg::TAG_SSND);
            put32(8);
        end
        if (junk) begin
            put32($urandom_range(0, 1) ? 32'h4E414D45 : {$urandom});
            put32(junk);
            repeat (junk + junk % 2) file_bytes.push_back(8'($urandom));
        end
        if (mode != 5) begin
            put32(aiffcw_pkg::TAG_COMM);
            put32(mode == 9 ? $urandom_range(0, 17) : 18);
            put16(16'(chans));
            put32(frames);
            put16(16'(depth));
            file_bytes.push_back(8'($urandom));
            file_bytes.push_back($urandom_range(0, 3) != 0 ? 8'(14 - $urandom_range(0, 24))
                                                           : 8'($urandom));
            put32($urandom);
            put32($urandom);
        end
        if (mode == 3) begin
            put32(aiffcw_pkg::TAG_COMM);
            put32(18);
        end
        put32(aiffcw_pkg::TAG_SSND);
        put32(ssnd_size);
        put32(offs);
        put32(mode == 13 ? 32'hFFFF_FFF0 : blk);
        repeat (offs) file_bytes.push_back(8'($urandom));
        for (int i = 0; i < snd; i++) begin
            if (mode == 7 || (i % nb) != 0 || depth % 8 == 0)
                file_bytes.push_back(8'($urandom));
            else
                file_bytes.push_back($urandom_range(0, 1) ? 8'h00 : 8'hFF);
        end
        repeat (blk + ssnd_size % 2) file_bytes.push_back(8'($urandom));
        if (mode == 4) begin
            put32(aiffcw_pkg::TAG_SSND);
            put32(8);
        end
        if (mode == 8)
            repeat ($urandom_range(1, 6)) void'(file_bytes.pop_back());
        if (mode == 14)
            repeat ($urandom_range(1, 4)) file_bytes.push_back(8'($urandom));
    endtask

    task automatic random_file();
        int mode, dsel, depth;
        mode = ($urandom_range(0, 99) < 65) ? 0 : $urandom_range(1, 14);
        dsel = $urandom_range(0, 9);
        depth = (dsel < 6) ? 8 * $urandom_range(1, 4) : $urandom_range(1, 40);
        build_file(mode, $urandom_range(1, 3), $urandom_range(0, 4), depth);
        send_file();
    endtask

    task automatic drain_results();
        while (pending != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    initial
    begin
        repeat (4) @(negedge clk);
        rst_n <= 1;
        @(negedge clk);

        // Directed files for every status and depth extreme, spread over the idling phases.
        for (int p = 0; p < 4; p++) begin
            case (p)
                0: begin send_idle_pct = 0;  stall_pct = 0;  end
                1: begin send_idle_pct = 75; stall_pct = 0;  end
                2: begin send_idle_pct = 0;  stall_pct = 75; end
                default: begin send_idle_pct = 26; stall_pct = 26; end
            endcase
            case (p)
                0:
                begin
                    build_file(0, 1, 2, 8);   send_file();
                    build_file(0, 2, 1, 32);  send_file();
                    build_file(0, 1, 1, 12);  send_file();
                    for (int m = 1; m <= 4; m++) begin
                        build_file(m, 1, 2, 16);
                        send_file();
                    end
                end
                1:
                begin
                    for (int m = 5; m <= 9; m++) begin
                        build_file(m, 1, 2, 16);
                        send_file();
                    end
                end
                2:
                begin
                    for (int m = 10; m <= 14; m++) begin
                        build_file(m, 1, 2, 16);
                        send_file();
                    end
                end
                default:
                begin
                    build_file(0, 1, 1, 0);   send_file();
                    build_file(0, 1, 1, 40);  send_file();
                    file_bytes.push_back(8'h00); send_file();
                    repeat (2) random_file();
                end
            endcase
            drain_results();
        end

        stall_pct = 0;
        send_idle_pct = 0;
        drain_results();
        repeat (10) @(negedge clk);
        $display("Sent %0d bytes in %0d files; checked %0d samples.",
                 bytes_sent, files_seen, samples_seen);
        if (failures == 0 && pending == 0)
            $display("aiff_chunk_walker_test: PASS");
        else
            $display("aiff_chunk_walker_test: FAIL");
        $finish;
    end

endmodule

/* filelist.f */
src/aiffcw_pkg.sv
src/aiffcw_ctrl.sv
src/aiffcw_dp.sv
src/aiff_chunk_walker.sv
dv/aiff_chunk_walker_checker.sv
dv/aiff_chunk_walker_test.sv
